// ===== hdl/pcrc_pkg.sv =====
`default_nettype none

package pcrc_pkg;

  // Widest remainder the block is built for by default.
  localparam int MAX_WIDTH_DEF = 32;

  // Register file layout.
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_WIDTH_W = 6;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_WIDTH_W-1:0] CRC_WIDTH_RST  = 6'd8;
  localparam logic [CFG_DATA_W-1:0]  POLYNOMIAL_RST = 32'd7;

  // Byte count field of the load request; four bits, so it holds up to 15 bytes.
  localparam int LOAD_CNT_W = 4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CRC_WIDTH  = 1'b0,
    REG_POLYNOMIAL = 1'b1
  } reg_index_t;

  // Request from the divider stage to the byte serializer.
  typedef struct packed {
    logic                  load;
    logic [LOAD_CNT_W-1:0] nbytes;
  } ser_load_t;

endpackage

`default_nettype wire

// ===== hdl/pcrc_div.sv =====
`default_nettype none

module pcrc_div #(
  parameter int MAX_WIDTH = pcrc_pkg::MAX_WIDTH_DEF,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int IW = $clog2(MAX_WIDTH)
) (
  input  logic [WW-1:0]        width,
  input  logic [MAX_WIDTH-1:0] poly,
  input  logic [MAX_WIDTH-1:0] rem_in,
  input  logic [7:0]           data,
  output logic [MAX_WIDTH-1:0] rem_out
);

  logic [MAX_WIDTH-1:0] mask;
  logic [MAX_WIDTH-1:0] poly_m;
  logic [MAX_WIDTH-1:0] rem;
  logic [IW-1:0]        top_idx;
  logic                 top;

  assign top_idx = IW'(width - WW'(1));

  // Eight bit steps of long division, bit 7 of the byte first.
  always_comb begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      mask[i] = (i < int'(width));
    end
    poly_m = poly & mask;
    rem    = rem_in & mask;
    top    = 1'b0;
    for (int b = 7; b >= 0; b--) begin
      top = rem[top_idx] ^ data[b];
      rem = (rem << 1) & mask;
      if (top) begin
        rem = rem ^ poly_m;
      end
    end
    rem_out = rem;
  end

endmodule

`default_nettype wire

// ===== hdl/pcrc_ser.sv =====
`default_nettype none

module pcrc_ser #(
  parameter int MAX_WIDTH = pcrc_pkg::MAX_WIDTH_DEF,
  localparam int NB = (MAX_WIDTH + 7) / 8,
  localparam int BW = NB * 8,
  localparam int LW = $clog2(NB + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pcrc_pkg::ser_load_t  ctl,
  input  logic [MAX_WIDTH-1:0] crc,
  output logic                 idle,
  output logic                 crc_valid,
  input  logic                 crc_ready,
  output logic [7:0]           crc_byte,
  output logic                 last_byte
);

  logic [BW-1:0] shreg;
  logic [LW-1:0] left;
  logic [LW-1:0] nb;

  assign nb = LW'(ctl.nbytes);

  // Left-align the remainder so the most significant used byte sits on top.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      shreg <= BW'(crc) << ((NB - int'(nb)) * 8);
    end else if (crc_valid && crc_ready) begin
      shreg <= shreg << 8;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
    end else if (ctl.load) begin
      left <= nb;
    end else if (crc_valid && crc_ready) begin
      left <= left - LW'(1);
    end
  end

  assign idle      = (left == '0);
  assign crc_valid = !idle;
  assign crc_byte  = shreg[BW-1 -: 8];
  assign last_byte = (left == LW'(1));

endmodule

`default_nettype wire

// ===== hdl/programmable_crc_generator.sv =====
`default_nettype none

// Programmable CRC generator, MSB first, non-reflected. Packet bytes enter on the
// data channel (bit 7 divided first, last marks the packet's final byte) and the
// running remainder is updated by plain long division with a zero start value and
// no final XOR. The divisor has degree crc_width (0 is taken as 1, values above
// MAX_WIDTH as MAX_WIDTH) with an implied leading one above the low crc_width bits
// of polynomial. On the last byte the remainder goes out on the crc channel as
// ceil(width/8) beats, most significant byte first with zero padding on the left,
// last_byte set on the final one, and the remainder restarts at zero. Rate: one
// data beat per clock; the eight bit steps for a byte are combinational between
// the input register and the remainder register. A last byte waits in the input
// register until the serializer has sent every byte of the previous CRC, so a
// last byte that follows a CRC may hold off the data channel while those bytes
// go out, and longer while the CRC channel keeps crc_ready low.
// Write configuration only while no packet is in flight and no CRC beat is pending.
module programmable_crc_generator #(
  parameter int MAX_WIDTH = pcrc_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_we,
  input  logic [pcrc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pcrc_pkg::CFG_DATA_W-1:0]  cfg_data,
  // packet byte channel
  input  logic                            data_valid,
  output logic                            data_ready,
  input  logic [7:0]                      data_byte,
  input  logic                            last,
  // CRC byte channel
  output logic                            crc_valid,
  input  logic                            crc_ready,
  output logic [7:0]                      crc_byte,
  output logic                            last_byte
);

  localparam int WW = $clog2(MAX_WIDTH + 1);

  // Configuration registers.
  logic [pcrc_pkg::CFG_WIDTH_W-1:0] crc_width;
  logic [pcrc_pkg::CFG_DATA_W-1:0]  polynomial;

  // Input register.
  logic       s1_valid;
  logic [7:0] s1_data;
  logic       s1_last;
  logic       s1_go;

  // Running remainder.
  logic [MAX_WIDTH-1:0] remainder;
  logic [MAX_WIDTH-1:0] remainder_next;

  logic [6:0]           width_sat;
  logic [WW-1:0]        eff_w;
  logic [WW:0]          w_plus;
  logic [MAX_WIDTH-1:0] poly_w;
  logic [MAX_WIDTH-1:0] rem_div;

  pcrc_pkg::ser_load_t  ld;
  logic                 ser_idle;

  // Write configuration; only the defined fields of each register are kept.
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_width  <= pcrc_pkg::CRC_WIDTH_RST;
      polynomial <= pcrc_pkg::POLYNOMIAL_RST;
    end else if (cfg_we) begin
      case (pcrc_pkg::reg_index_t'(cfg_index))
        pcrc_pkg::REG_CRC_WIDTH:  crc_width  <= cfg_data[pcrc_pkg::CFG_WIDTH_W-1:0];
        pcrc_pkg::REG_POLYNOMIAL: polynomial <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the width to 1..MAX_WIDTH.
  always_comb begin
    if (crc_width == '0) begin
      width_sat = 7'd1;
    end else if (int'(crc_width) > MAX_WIDTH) begin
      width_sat = 7'(MAX_WIDTH);
    end else begin
      width_sat = 7'(crc_width);
    end
  end

  assign eff_w  = WW'(width_sat);
  assign w_plus = {1'b0, eff_w} + (WW+1)'(7);
  assign poly_w = MAX_WIDTH'(polynomial);

  // A last byte moves on only into an empty serializer; other bytes never wait.
  assign s1_go      = s1_valid && (!s1_last || ser_idle);
  assign data_ready = !s1_valid || s1_go;

  // Capture a beat whenever the input register frees up.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (data_ready) begin
      s1_valid <= data_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (data_ready && data_valid) begin
      s1_data <= data_byte;
      s1_last <= last;
    end
  end

  pcrc_div #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_div (
    .width   (eff_w),
    .poly    (poly_w),
    .rem_in  (remainder),
    .data    (s1_data),
    .rem_out (rem_div)
  );

  // Drop the remainder back to zero once a packet's CRC has been handed off.
  always_comb begin
    remainder_next = remainder;
    if (s1_go) begin
      remainder_next = s1_last ? '0 : rem_div;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remainder <= '0;
    end else begin
      remainder <= remainder_next;
    end
  end

  assign ld.load   = s1_go && s1_last;
  assign ld.nbytes = pcrc_pkg::LOAD_CNT_W'(w_plus >> 3);

  pcrc_ser #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ser (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ld),
    .crc       (rem_div),
    .idle      (ser_idle),
    .crc_valid (crc_valid),
    .crc_ready (crc_ready),
    .crc_byte  (crc_byte),
    .last_byte (last_byte)
  );

  // A finished packet leaves a zero remainder behind.
  a_rem_clear: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_last) |=> (remainder == '0))
    else $error("remainder not cleared after last byte");

  // Never overwrite a CRC that is still going out.
  a_load_empty: assert property (@(posedge clk) disable iff (rst)
    ld.load |-> !crc_valid)
    else $error("serializer loaded while busy");

  // The final CRC beat empties the serializer.
  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    (crc_valid && crc_ready && last_byte) |=> !crc_valid)
    else $error("CRC beats continue past last_byte");

  // A held last byte blocks new input until the serializer is free.
  a_last_stall: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_last && crc_valid) |-> !data_ready)
    else $error("input accepted past a waiting last byte");

endmodule

`default_nettype wire
